### rtl/btt_pkg.sv
// shared types and constants for the button release timeout tracker
// no dependencies
package btt_pkg;

    localparam int BUTTON_COUNT    = 24;
    localparam int SLOT_W          = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int BUTTON_W        = 5;
    localparam int CODE_W          = 8;
    localparam int COUNT_W         = 8;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};

    localparam logic KIND_PRESS = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic EVENT_PRESSED  = 1'b0;
    localparam logic EVENT_RELEASED = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [CODE_W-1:0]   key_code;
        logic [BUTTON_W-1:0] button_index;
        logic                button_known;
    } cmd_t;

    typedef struct packed {
        logic                event_res;
        logic [BUTTON_W-1:0] button;
        logic [CODE_W-1:0]   last_key;
        logic                last;
    } result_t;

    typedef struct packed {
        logic               active;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/btt_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module btt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/button_release_timeout_tracker.sv
// button release timeout tracker top level
// depends on btt_pkg and btt_ram
//
// usage
// - command channel: a word on cmd is taken at a clock edge with start high
//   and busy low
// - result channel: each result word sits on result for one cycle with
//   result_valid high; the receiver cannot stall, every word must be taken
// - config: cfg_we writes cfg_wdata into the release threshold; the user
//   must write it only while idle; the block does not enforce this
// - press report with a known in-range slot: a pressed word (if the slot was
//   inactive) is valid in the cycle after the press state
// - press report with an unknown slot: only updates the last key, no busy
// - tick: the slot state ram is read one slot per cycle and written back in
//   the following cycle; a released word is held until the next released slot
//   is found or the walk ends, so the final one carries last and is valid in
//   the first cycle with busy low
// - acceptance: a new command is taken only once busy is low again
// - reset: all slots read as inactive with zero count through per-slot valid
//   bits, threshold is 5, last key is 0; no clearing pass is needed
module button_release_timeout_tracker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  btt_pkg::cmd_t         cmd,
    output logic                  result_valid,
    output btt_pkg::result_t      result,
    input  logic                  cfg_we,
    input  logic [btt_pkg::COUNT_W-1:0] cfg_wdata
);

    import btt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRESS,
        S_WALK,
        S_DRAIN,
        S_FLUSH
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BUTTON_COUNT - 1);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   walk_reg, walk_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]   proc_slot_reg, proc_slot_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic [CODE_W-1:0]   last_code_reg, last_code_next;
    logic [COUNT_W-1:0]  threshold_reg, threshold_next;
    logic [BUTTON_COUNT-1:0] valid_reg, valid_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    logic                accept;
    logic                press_hit;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    entry_t              ram_wentry;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              cur;

    btt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUTTON_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign press_hit    = cmd.button_known && (int'(cmd.button_index) < BUTTON_COUNT);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        cur = valid_reg[proc_slot_reg] ? entry_t'(ram_rdata) : '0;
    end

    always_comb
    begin
        state_next        = state_reg;
        walk_next         = walk_reg;
        rd_pend_next      = 1'b0;
        proc_slot_next    = proc_slot_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        last_code_next    = last_code_reg;
        threshold_next    = cfg_we ? cfg_wdata : threshold_reg;
        valid_next        = valid_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = proc_slot_reg;
        ram_wentry        = '0;
        ram_re            = 1'b0;
        ram_raddr         = walk_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.kind == KIND_PRESS)
                    begin
                        last_code_next = cmd.key_code;
                        if (press_hit)
                        begin
                            ram_re         = 1'b1;
                            ram_raddr      = SLOT_W'(cmd.button_index);
                            proc_slot_next = SLOT_W'(cmd.button_index);
                            state_next     = S_PRESS;
                        end
                    end
                    else
                    begin
                        walk_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_WALK;
                    end
                end
            end
            S_PRESS:
            begin
                ram_we                  = 1'b1;
                ram_wentry.active       = 1'b1;
                ram_wentry.count        = '0;
                valid_next[proc_slot_reg] = 1'b1;
                if (!cur.active)
                begin
                    result_valid_next     = 1'b1;
                    result_next.event_res = EVENT_PRESSED;
                    result_next.button    = BUTTON_W'(32'(proc_slot_reg));
                    result_next.last_key  = last_code_reg;
                    result_next.last      = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                ram_re         = 1'b1;
                ram_raddr      = walk_reg;
                rd_pend_next   = 1'b1;
                proc_slot_next = walk_reg;
                if (walk_reg == LAST_SLOT)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    walk_next = walk_reg + SLOT_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    result_valid_next     = 1'b1;
                    result_next.event_res = EVENT_RELEASED;
                    result_next.button    = BUTTON_W'(32'(pend_slot_reg));
                    result_next.last_key  = last_code_reg;
                    result_next.last      = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // read-modify-write of one slot during the tick walk
        if (rd_pend_reg)
        begin
            if (cur.count > threshold_reg)
            begin
                if (cur.active)
                begin
                    ram_we                    = 1'b1;
                    ram_wentry                = '0;
                    valid_next[proc_slot_reg] = 1'b1;
                    if (pend_valid_reg)
                    begin
                        result_valid_next     = 1'b1;
                        result_next.event_res = EVENT_RELEASED;
                        result_next.button    = BUTTON_W'(32'(pend_slot_reg));
                        result_next.last_key  = last_code_reg;
                        result_next.last      = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = proc_slot_reg;
                end
            end
            else if (cur.active && (cur.count != COUNT_MAX))
            begin
                ram_we                    = 1'b1;
                ram_wentry.active         = 1'b1;
                ram_wentry.count          = cur.count + COUNT_W'(1);
                valid_next[proc_slot_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            walk_reg         <= '0;
            rd_pend_reg      <= 1'b0;
            proc_slot_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            pend_slot_reg    <= '0;
            last_code_reg    <= '0;
            threshold_reg    <= THRESHOLD_RESET;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            walk_reg         <= walk_next;
            rd_pend_reg      <= rd_pend_next;
            proc_slot_reg    <= proc_slot_next;
            pend_valid_reg   <= pend_valid_next;
            pend_slot_reg    <= pend_slot_next;
            last_code_reg    <= last_code_next;
            threshold_reg    <= threshold_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    // state ram is only written while a command is in progress
    assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> busy)
        else $error("state ram written while idle");

    // a pressed word is always the only word of its press report
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.event_res == EVENT_PRESSED) |-> result.last)
        else $error("pressed word without last");

    // results only name existing slots
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (int'(result.button) < BUTTON_COUNT))
        else $error("result slot out of range");

    // walk reads stop once the walk leaves its state
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_WALK || state_reg == S_DRAIN))
        else $error("slot processed outside a tick walk");

endmodule
